### hdl/hgs_pkg.sv
// ----------------------------------------------------------------------------
// hgs_pkg
// Shared constants, codes and helper functions for the height grid sampler.
// ----------------------------------------------------------------------------
package hgs_pkg;

  // Grid geometry and number formats.
  localparam int MAX_COLUMNS   = 256;
  localparam int MAX_ROWS      = 256;
  localparam int FRACTION_BITS = 8;
  localparam int COORD_W       = 16;
  localparam int INT_W         = COORD_W - FRACTION_BITS;
  localparam int HEIGHT_W      = 24;
  localparam int DIM_W         = 9;
  localparam int ADDR_W        = $clog2(MAX_COLUMNS * MAX_ROWS);
  localparam int COUNT_W       = ADDR_W + 1;
  localparam int RATIO_W       = FRACTION_BITS + 1;

  // Normalize arithmetic: differences of two heights and their product.
  localparam int DIFF_W = HEIGHT_W + 1;
  localparam int PROD_W = 2 * DIFF_W - 1;
  localparam int MAG_W  = PROD_W - 1;
  localparam int DVS_W  = DIFF_W - 1;
  localparam int SUM_W  = PROD_W + 1;

  // Operation codes.
  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_SAMPLE    = 2'd1;
  localparam logic [1:0] OP_NORMALIZE = 2'd2;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  // Configuration register indexes.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic signed [SUM_W-1:0] H_MAXV = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] H_MINV = -SUM_W'(8388608);

  // Saturate a wide signed value to a height.
  function automatic logic signed [HEIGHT_W-1:0] sat_height(input logic signed [SUM_W-1:0] v);
    logic signed [HEIGHT_W-1:0] r;
    if (v > H_MAXV) begin
      r = H_MAXV[HEIGHT_W-1:0];
    end else if (v < H_MINV) begin
      r = H_MINV[HEIGHT_W-1:0];
    end else begin
      r = v[HEIGHT_W-1:0];
    end
    return r;
  endfunction

  // Clamp a grid dimension register to 2..top.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] top);
    logic [DIM_W-1:0] r;
    if (v < DIM_W'(2)) begin
      r = DIM_W'(2);
    end else if (v > top) begin
      r = top;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### hdl/hgs_if.sv
// ----------------------------------------------------------------------------
// hgs_in_if / hgs_out_if
// Valid/ready channels for operations into and results out of the sampler.
// ----------------------------------------------------------------------------
interface hgs_in_if;
  import hgs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic [COORD_W-1:0]         x_coord;
  logic [COORD_W-1:0]         y_coord;
  logic signed [HEIGHT_W-1:0] height_value;
  logic signed [HEIGHT_W-1:0] target_low;
  logic signed [HEIGHT_W-1:0] target_high;

  modport source(output valid, operation, x_coord, y_coord, height_value,
                 target_low, target_high, input ready);
  modport sink(input valid, operation, x_coord, y_coord, height_value,
               target_low, target_high, output ready);
endinterface

interface hgs_out_if;
  import hgs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       status;
  logic signed [HEIGHT_W-1:0] sampled_height;
  logic signed [HEIGHT_W-1:0] min_height;
  logic signed [HEIGHT_W-1:0] max_height;

  modport source(output valid, status, sampled_height, min_height, max_height,
                 input ready);
  modport sink(input valid, status, sampled_height, min_height, max_height,
               output ready);
endinterface

### hdl/hgs_div.sv
// ----------------------------------------------------------------------------
// hgs_div
// Radix-2 restoring divider, signed, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module hgs_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [hgs_pkg::PROD_W-1:0]   dividend,
  input  logic signed [hgs_pkg::DIFF_W-1:0]   divisor,
  output logic                                done,
  output logic signed [hgs_pkg::PROD_W-1:0]   quotient
);
  import hgs_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [MAG_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W:0]    rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              neg;
  logic [DVS_W:0]    rem_sh;
  logic              fits;
  logic [PROD_W-1:0] abs_dvd;
  logic [DIFF_W-1:0] abs_dvs;

  // Magnitudes of the operands.
  assign abs_dvd = dividend[PROD_W-1] ? PROD_W'(-dividend) : PROD_W'(dividend);
  assign abs_dvs = divisor[DIFF_W-1] ? DIFF_W'(-divisor) : DIFF_W'(divisor);

  // One quotient bit per cycle.
  assign rem_sh = {rem[DVS_W-1:0], dvd[MAG_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MAG_W);
        rem  <= '0;
        dvd  <= abs_dvd[MAG_W-1:0];
        dvs  <= abs_dvs[DVS_W-1:0];
        neg  <= dividend[PROD_W-1] ^ divisor[DIFF_W-1];
      end else if (busy) begin
        rem <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
        dvd <= {dvd[MAG_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Apply the sign to the magnitude quotient.
  assign quotient = neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});

endmodule

### hdl/height_grid_bilinear_sampler_unit.sv
// ----------------------------------------------------------------------------
// height_grid_bilinear_sampler_unit
// Height grid in one synchronous memory with write, bilinear sample and
// normalize operations and a running minimum and maximum.
// ----------------------------------------------------------------------------
// Usage:
//   Operations arrive on in_chan; each produces exactly one result transfer
//   on out_chan carrying a status, the sampled height and the current
//   minimum and maximum. grid_width and grid_height are written through the
//   cfg_we / cfg_index / cfg_data port while the block is idle.
// Steps per operation, sharing the single memory port and the divider:
//   write      one memory write, then the result.
//   sample     four cell reads from the one port, then five
//              interpolation steps sharing one multiplier.
//   normalize  per cell in use: read, multiply, a 48-step divider,
//              write back; the divider is skipped when min equals max.
// The next operation is taken as soon as the sequencer is idle, even while
// the previous result still waits in the output register.
// Reset clears the sequencer, the running range and the output valid flag,
// and restores both dimensions to 256; grid cells are undefined until
// written. When the receiver stalls, the result is held and the block stops
// once its next result has nowhere to go.
// ----------------------------------------------------------------------------
module height_grid_bilinear_sampler_unit (
  input  logic                        clk,
  input  logic                        rst,
  hgs_in_if.sink                      in_chan,
  hgs_out_if.source                   out_chan,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [hgs_pkg::DIM_W-1:0]   cfg_data
);
  import hgs_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_SRD    = 14'b00000000000010,
    S_SWAIT  = 14'b00000000000100,
    S_L0     = 14'b00000000001000,
    S_L1     = 14'b00000000010000,
    S_L2     = 14'b00000000100000,
    S_L3     = 14'b00000001000000,
    S_L4     = 14'b00000010000000,
    S_NRD    = 14'b00000100000000,
    S_NMUL   = 14'b00001000000000,
    S_NDIVS  = 14'b00010000000000,
    S_NDIV   = 14'b00100000000000,
    S_NWR    = 14'b01000000000000,
    S_RESULT = 14'b10000000000000
  } state_t;

  state_t state;
  logic   in_result;

  // Configuration.
  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  // Running range.
  logic signed [HEIGHT_W-1:0] lowest_seen;
  logic signed [HEIGHT_W-1:0] highest_seen;
  logic                       range_seeded;

  // Memory.
  logic [HEIGHT_W-1:0] mem [0:(1 << ADDR_W)-1];
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [HEIGHT_W-1:0] mem_wdata;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_raddr;
  logic signed [HEIGHT_W-1:0] mem_q;

  // Decoded input.
  logic                 accept;
  logic [INT_W-1:0]     xi;
  logic [INT_W-1:0]     yi;
  logic [FRACTION_BITS-1:0] xf;
  logic [FRACTION_BITS-1:0] yf;
  logic                 wr_ok;
  logic [ADDR_W-1:0]    wr_addr;
  logic                 x_ok;
  logic                 y_ok;
  logic [INT_W-1:0]     x0;
  logic [INT_W-1:0]     y0;
  logic [RATIO_W-1:0]   rx_in;
  logic [RATIO_W-1:0]   ry_in;
  logic [ADDR_W-1:0]    sample_base;

  // Sample datapath.
  logic [ADDR_W-1:0]          base_addr;
  logic [RATIO_W-1:0]         rx;
  logic [RATIO_W-1:0]         ry;
  logic [2:0]                 rcnt;
  logic                       rd_pend;
  logic [1:0]                 rd_k;
  logic signed [HEIGHT_W-1:0] f [0:3];
  logic signed [DIFF_W+1:0]   lerp_a;
  logic signed [DIFF_W+1:0]   lerp_b;
  logic signed [DIFF_W+1:0]   lerp_d;
  logic [RATIO_W-1:0]         lerp_r;
  logic signed [DIFF_W+RATIO_W+2:0] p;
  logic signed [DIFF_W:0]     f0r;
  logic signed [DIFF_W:0]     f1r;
  logic signed [DIFF_W+RATIO_W+2:0] p_sh;

  // Normalize datapath.
  logic signed [HEIGHT_W-1:0] tl;
  logic signed [HEIGHT_W-1:0] th;
  logic signed [DIFF_W-1:0]   span_new;
  logic signed [DIFF_W-1:0]   span_old;
  logic                       span_zero;
  logic [COUNT_W-1:0]         idx;
  logic [COUNT_W-1:0]         cells_n;
  logic signed [PROD_W-1:0]   prod;
  logic                       div_start;
  logic                       div_done;
  logic signed [PROD_W-1:0]   div_q;
  logic signed [HEIGHT_W-1:0] norm_val;

  // Result staging and output register.
  logic                       res_status;
  logic signed [HEIGHT_W-1:0] res_sample;
  logic                       out_valid;
  logic                       load_out;

  assign in_result = (state == S_RESULT);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_W'(256);
      grid_height <= DIM_W'(256);
    end else if (cfg_we) begin
      if (cfg_index == REG_GRID_WIDTH) begin
        grid_width <= cfg_data;
      end else begin
        grid_height <= cfg_data;
      end
    end
  end

  assign w_eff = clamp_dim(grid_width, DIM_W'(MAX_COLUMNS));
  assign h_eff = clamp_dim(grid_height, DIM_W'(MAX_ROWS));

  // Input decode: write range and sample coordinate split.
  assign accept  = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state == S_IDLE);
  assign xi = in_chan.x_coord[COORD_W-1:FRACTION_BITS];
  assign yi = in_chan.y_coord[COORD_W-1:FRACTION_BITS];
  assign xf = in_chan.x_coord[FRACTION_BITS-1:0];
  assign yf = in_chan.y_coord[FRACTION_BITS-1:0];
  assign wr_ok   = ({1'b0, xi} < w_eff) && ({1'b0, yi} < h_eff);
  assign wr_addr = ADDR_W'({1'b0, xi} + yi * w_eff);

  always_comb begin
    x_ok  = 1'b0;
    x0    = xi;
    rx_in = {1'b0, xf};
    if ({1'b0, xi} < w_eff - DIM_W'(1)) begin
      x_ok = 1'b1;
    end else if (({1'b0, xi} == w_eff - DIM_W'(1)) && (xf == '0)) begin
      x_ok  = 1'b1;
      x0    = INT_W'(w_eff - DIM_W'(2));
      rx_in = RATIO_W'(1 << FRACTION_BITS);
    end
    y_ok  = 1'b0;
    y0    = yi;
    ry_in = {1'b0, yf};
    if ({1'b0, yi} < h_eff - DIM_W'(1)) begin
      y_ok = 1'b1;
    end else if (({1'b0, yi} == h_eff - DIM_W'(1)) && (yf == '0)) begin
      y_ok  = 1'b1;
      y0    = INT_W'(h_eff - DIM_W'(2));
      ry_in = RATIO_W'(1 << FRACTION_BITS);
    end
  end

  assign sample_base = ADDR_W'({1'b0, x0} + y0 * w_eff);

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = in_chan.height_value;
    mem_re    = 1'b0;
    mem_raddr = idx[ADDR_W-1:0];
    if (accept && (in_chan.operation == OP_WRITE) && wr_ok) begin
      mem_we = 1'b1;
    end else if (state == S_NWR) begin
      mem_we    = 1'b1;
      mem_waddr = idx[ADDR_W-1:0];
      mem_wdata = norm_val;
    end
    if (state == S_SRD) begin
      mem_re = 1'b1;
      case (rcnt[1:0])
        2'd0:    mem_raddr = base_addr;
        2'd1:    mem_raddr = base_addr + ADDR_W'(1);
        2'd2:    mem_raddr = ADDR_W'(base_addr + w_eff);
        default: mem_raddr = ADDR_W'(base_addr + w_eff + ADDR_W'(1));
      endcase
    end else if (state == S_NRD) begin
      mem_re = 1'b1;
    end
  end

  // Height store.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // Interpolation operand selection for the shared multiplier.
  always_comb begin
    lerp_a = (DIFF_W+2)'(f[0]);
    lerp_b = (DIFF_W+2)'(f[2]);
    lerp_r = ry;
    case (state)
      S_L1:    begin
        lerp_a = (DIFF_W+2)'(f[1]);
        lerp_b = (DIFF_W+2)'(f[3]);
      end
      S_L3:    begin
        lerp_a = (DIFF_W+2)'(f0r);
        lerp_b = (DIFF_W+2)'(f1r);
        lerp_r = rx;
      end
      default: begin
        lerp_a = (DIFF_W+2)'(f[0]);
        lerp_b = (DIFF_W+2)'(f[2]);
      end
    endcase
    lerp_d = lerp_b - lerp_a;
  end

  assign p_sh = p >>> FRACTION_BITS;

  // Normalized value of the current cell.
  always_comb begin
    if (span_zero) begin
      norm_val = sat_height(SUM_W'(tl) + SUM_W'(span_new >>> 1));
    end else begin
      norm_val = sat_height(SUM_W'(tl) + SUM_W'(div_q));
    end
  end

  assign div_start = (state == S_NDIVS);
  assign load_out  = in_result && (!out_valid || out_chan.ready);

  hgs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (span_old),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      lowest_seen  <= '0;
      highest_seen <= '0;
      range_seeded <= 1'b0;
      rd_pend      <= 1'b0;
      rcnt         <= '0;
      idx          <= '0;
    end else begin
      rd_pend <= (state == S_SRD);
      rd_k    <= rcnt[1:0];
      if (rd_pend) begin
        f[rd_k] <= mem_q;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_sample <= '0;
            case (in_chan.operation)
              OP_WRITE: begin
                state <= S_RESULT;
                if (wr_ok) begin
                  res_status   <= STATUS_OK;
                  range_seeded <= 1'b1;
                  if (!range_seeded || (in_chan.height_value < lowest_seen)) begin
                    lowest_seen <= in_chan.height_value;
                  end
                  if (!range_seeded || (in_chan.height_value > highest_seen)) begin
                    highest_seen <= in_chan.height_value;
                  end
                end else begin
                  res_status <= STATUS_RANGE;
                end
              end
              OP_SAMPLE: begin
                if (x_ok && y_ok) begin
                  state      <= S_SRD;
                  res_status <= STATUS_OK;
                  rcnt       <= '0;
                  base_addr  <= sample_base;
                  rx         <= rx_in;
                  ry         <= ry_in;
                end else begin
                  state      <= S_RESULT;
                  res_status <= STATUS_RANGE;
                end
              end
              OP_NORMALIZE: begin
                state      <= S_NRD;
                res_status <= STATUS_OK;
                idx        <= '0;
                cells_n    <= COUNT_W'(w_eff * h_eff);
                tl         <= in_chan.target_low;
                th         <= in_chan.target_high;
                span_new   <= DIFF_W'(in_chan.target_high) - DIFF_W'(in_chan.target_low);
                span_old   <= DIFF_W'(highest_seen) - DIFF_W'(lowest_seen);
                span_zero  <= (highest_seen == lowest_seen);
              end
              default: begin
                state      <= S_RESULT;
                res_status <= STATUS_RANGE;
              end
            endcase
          end
        end
        S_SRD: begin
          rcnt <= rcnt + 3'd1;
          if (rcnt == 3'd3) begin
            state <= S_SWAIT;
          end
        end
        S_SWAIT: state <= S_L0;
        S_L0: begin
          p     <= $signed({1'b0, lerp_r}) * lerp_d;
          state <= S_L1;
        end
        S_L1: begin
          f0r   <= (DIFF_W+1)'(f[0]) + (DIFF_W+1)'(p_sh);
          p     <= $signed({1'b0, lerp_r}) * lerp_d;
          state <= S_L2;
        end
        S_L2: begin
          f1r   <= (DIFF_W+1)'(f[1]) + (DIFF_W+1)'(p_sh);
          state <= S_L3;
        end
        S_L3: begin
          p     <= $signed({1'b0, lerp_r}) * lerp_d;
          state <= S_L4;
        end
        S_L4: begin
          res_sample <= sat_height(SUM_W'(f0r) + SUM_W'(p_sh));
          state      <= S_RESULT;
        end
        S_NRD: state <= S_NMUL;
        S_NMUL: begin
          prod  <= (DIFF_W'(mem_q) - DIFF_W'(lowest_seen)) * span_new;
          state <= span_zero ? S_NWR : S_NDIVS;
        end
        S_NDIVS: state <= S_NDIV;
        S_NDIV: begin
          if (div_done) begin
            state <= S_NWR;
          end
        end
        S_NWR: begin
          idx <= idx + COUNT_W'(1);
          if (idx + COUNT_W'(1) == cells_n) begin
            lowest_seen  <= tl;
            highest_seen <= th;
            range_seeded <= 1'b1;
            state        <= S_RESULT;
          end else begin
            state <= S_NRD;
          end
        end
        S_RESULT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_chan.status         <= res_status;
      out_chan.sampled_height <= res_sample;
      out_chan.min_height     <= lowest_seen;
      out_chan.max_height     <= highest_seen;
    end
  end

  assign out_chan.valid = out_valid;

`ifndef ASSERT_OFF
  a_no_write_in_sample: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRD || state == S_SWAIT) |-> !mem_we)
    else $error("memory written while sample reads are in flight");

  a_div_start_once: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == S_NDIV) && !div_start)
    else $error("divider start not followed by wait state");

  a_load_free_slot: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || out_chan.ready))
    else $error("result register overwritten while stalled");

  a_norm_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_NRD) |-> (idx < cells_n))
    else $error("normalize index past the grid");
`endif

endmodule

### tb/hgs_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hgs_result_checker
// Watches the operation and result channels and the register port of the
// height grid sampler. It keeps its own copy of the grid, the running range
// and the grid size. For each operation transfer it predicts the result, and
// it compares each result transfer, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module hgs_result_checker (
  input  logic                      clk,
  input  logic                      rst,
  hgs_in_if                         in_mon,
  hgs_out_if                        out_mon,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [hgs_pkg::DIM_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending
);
  import hgs_pkg::*;

  typedef struct packed {
    logic                       status;
    logic signed [HEIGHT_W-1:0] sampled;
    logic signed [HEIGHT_W-1:0] low;
    logic signed [HEIGHT_W-1:0] high;
  } grid_result_t;

  logic signed [HEIGHT_W-1:0] grid_copy [MAX_COLUMNS*MAX_ROWS];
  logic signed [HEIGHT_W-1:0] lowest;
  logic signed [HEIGHT_W-1:0] highest;
  logic                       seeded;
  logic [DIM_W-1:0]           width_reg;
  logic [DIM_W-1:0]           height_reg;
  grid_result_t               awaited_results [$];

  function automatic logic signed [HEIGHT_W-1:0] clip24(input longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[HEIGHT_W-1:0];
  endfunction

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] raw, input int top);
    if (raw < 2) return 2;
    if (raw > top) return top;
    return raw;
  endfunction

  // Splits a Q8.8 coordinate into base cell and ratio; the last line uses
  // the preceding pair with a full ratio.
  function automatic bit split_pos(input logic [COORD_W-1:0] c, input int unsigned size,
                                   output int unsigned base, output longint ratio);
    int unsigned ip;
    int unsigned fp;
    ip = c[COORD_W-1:FRACTION_BITS];
    fp = c[FRACTION_BITS-1:0];
    base = 0;
    ratio = 0;
    if (ip < size - 1) begin
      base = ip;
      ratio = fp;
      return 1'b1;
    end
    if (ip == size - 1 && fp == 0) begin
      base = size - 2;
      ratio = longint'(1) << FRACTION_BITS;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one operation to the copy of the grid and returns its result.
  function automatic grid_result_t apply_op(input logic [1:0] op,
                                            input logic [COORD_W-1:0] xc,
                                            input logic [COORD_W-1:0] yc,
                                            input logic signed [HEIGHT_W-1:0] hv,
                                            input logic signed [HEIGHT_W-1:0] tl,
                                            input logic signed [HEIGHT_W-1:0] th);
    grid_result_t r;
    int unsigned w;
    int unsigned h;
    int unsigned xi;
    int unsigned yi;
    int unsigned x0;
    int unsigned y0;
    int unsigned base;
    longint rx;
    longint ry;
    longint f00, f10, f01, f11, f0, f1;
    longint span_new;
    longint span_old;
    bit okx;
    bit oky;
    w = eff_dim(width_reg, MAX_COLUMNS);
    h = eff_dim(height_reg, MAX_ROWS);
    r.status = STATUS_OK;
    r.sampled = '0;
    case (op)
      OP_WRITE: begin
        xi = xc[COORD_W-1:FRACTION_BITS];
        yi = yc[COORD_W-1:FRACTION_BITS];
        if (xi < w && yi < h) begin
          grid_copy[xi + yi * w] = hv;
          if (!seeded) begin
            lowest = hv;
            highest = hv;
            seeded = 1'b1;
          end else begin
            if (hv < lowest) lowest = hv;
            if (hv > highest) highest = hv;
          end
        end else begin
          r.status = STATUS_RANGE;
        end
      end
      OP_SAMPLE: begin
        okx = split_pos(xc, w, x0, rx);
        oky = split_pos(yc, h, y0, ry);
        if (okx && oky) begin
          base = x0 + y0 * w;
          f00 = grid_copy[base];
          f10 = grid_copy[base + 1];
          f01 = grid_copy[base + w];
          f11 = grid_copy[base + w + 1];
          f0 = f00 + ((ry * (f01 - f00)) >>> FRACTION_BITS);
          f1 = f10 + ((ry * (f11 - f10)) >>> FRACTION_BITS);
          r.sampled = clip24(f0 + ((rx * (f1 - f0)) >>> FRACTION_BITS));
        end else begin
          r.status = STATUS_RANGE;
        end
      end
      OP_NORMALIZE: begin
        span_new = longint'(th) - longint'(tl);
        span_old = longint'(highest) - longint'(lowest);
        for (int unsigned i = 0; i < w * h; i++) begin
          if (span_old != 0) begin
            grid_copy[i] = clip24(longint'(tl) +
                ((longint'(grid_copy[i]) - longint'(lowest)) * span_new) / span_old);
          end else begin
            grid_copy[i] = clip24(longint'(tl) + (span_new >>> 1));
          end
        end
        lowest = tl;
        highest = th;
        seeded = 1'b1;
      end
      default: begin
        r.status = STATUS_RANGE;
      end
    endcase
    r.low = lowest;
    r.high = highest;
    return r;
  endfunction

  // Register writes, predictions on operation transfers and checks on
  // result transfers.
  always @(posedge clk) begin
    grid_result_t want;
    if (rst) begin
      lowest <= '0;
      highest <= '0;
      seeded <= 1'b0;
      width_reg <= DIM_W'(256);
      height_reg <= DIM_W'(256);
      awaited_results.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_GRID_WIDTH) width_reg <= cfg_data;
        else height_reg <= cfg_data;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result transfer, status %0d sampled %0d",
                   $time, out_mon.status, out_mon.sampled_height);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (out_mon.status !== want.status ||
              out_mon.sampled_height !== want.sampled ||
              out_mon.min_height !== want.low ||
              out_mon.max_height !== want.high) begin
            $display("%0t: mismatch expected st %0d smp %0d min %0d max %0d, got st %0d smp %0d min %0d max %0d",
                     $time, want.status, want.sampled, want.low, want.high,
                     out_mon.status, out_mon.sampled_height, out_mon.min_height,
                     out_mon.max_height);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        awaited_results.push_back(apply_op(in_mon.operation, in_mon.x_coord,
                                           in_mon.y_coord, in_mon.height_value,
                                           in_mon.target_low, in_mon.target_high));
      end
      pending <= awaited_results.size();
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the height grid sampler: seeding writes and special cases on
// the default and the smallest grid, then phases of grid sizes (extremes
// among them) with the cells in use filled first (a corner region on the
// largest grids) and random writes, samples, normalizes and bad items.
// Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb;
  import hgs_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [DIM_W-1:0] cfg_data;
  int               fail_count;
  int               pending;
  int               gap_pct;
  int               stall_pct;
  int               quiet_cycles;
  int unsigned      cur_w;
  int unsigned      cur_h;
  int unsigned      fill_w;
  int unsigned      fill_h;

  hgs_in_if  in_chan();
  hgs_out_if out_chan();

  height_grid_bilinear_sampler_unit dut (
    .clk(clk), .rst(rst), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hgs_result_checker checker_i (
    .clk(clk), .rst(rst), .in_mon(in_chan), .out_mon(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Receiver side stalls at random.
  always @(posedge clk) begin
    out_chan.ready <= !rst && ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one operation and holds it until the transfer.
  task automatic send_op(input logic [1:0] op, input int unsigned xc, input int unsigned yc,
                         input int hv, input int tl, input int th);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < gap_pct) gap++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.operation <= op;
    in_chan.x_coord <= COORD_W'(xc);
    in_chan.y_coord <= COORD_W'(yc);
    in_chan.height_value <= HEIGHT_W'(hv);
    in_chan.target_low <= HEIGHT_W'(tl);
    in_chan.target_high <= HEIGHT_W'(th);
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Ends a phase: no offer, every result in, then a short pause.
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_grid(input int unsigned w_raw, input int unsigned h_raw);
    cfg_we <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data <= DIM_W'(w_raw);
    @(posedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data <= DIM_W'(h_raw);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_w = (w_raw < 2) ? 2 : (w_raw > MAX_COLUMNS) ? MAX_COLUMNS : w_raw;
    cur_h = (h_raw < 2) ? 2 : (h_raw > MAX_ROWS) ? MAX_ROWS : h_raw;
    fill_w = cur_w;
    fill_h = cur_h;
  endtask

  function automatic int pick_height();
    case ($urandom_range(0, 5))
      0: return -8388608;
      1: return 8388607;
      2: return $urandom_range(0, 2000) - 1000;
      default: return $urandom();
    endcase
  endfunction

  // Writes every cell of the filled region so that later reads only see
  // written cells.
  task automatic fill_grid();
    for (int unsigned yy = 0; yy < fill_h; yy++) begin
      for (int unsigned xx = 0; xx < fill_w; xx++) begin
        send_op(OP_WRITE, (xx << 8) | $urandom_range(0, 255),
                (yy << 8) | $urandom_range(0, 255), pick_height(), $urandom(), $urandom());
      end
    end
  endtask

  // Good samples and writes stay in the filled region; normalize only runs
  // when the whole grid is filled, and wild samples miss every row otherwise.
  task automatic random_ops(input int count);
    int pick;
    int norm_pct;
    bit full;
    full = (fill_w == cur_w) && (fill_h == cur_h);
    norm_pct = !full ? 0 : (cur_w * cur_h <= 64) ? 6 : 1;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < norm_pct) begin
        send_op(OP_NORMALIZE, $urandom(), $urandom(), $urandom(), pick_height(), pick_height());
      end else if (pick < 45) begin
        send_op(OP_WRITE, ($urandom_range(0, fill_w - 1) << 8) | $urandom_range(0, 255),
                ($urandom_range(0, fill_h - 1) << 8) | $urandom_range(0, 255),
                pick_height(), $urandom(), $urandom());
      end else if (pick < 88) begin
        send_op(OP_SAMPLE, $urandom_range(0, (fill_w - 1) << 8),
                $urandom_range(0, (fill_h - 1) << 8), $urandom(), $urandom(), $urandom());
      end else if (pick < 94) begin
        send_op(OP_WRITE, $urandom(), $urandom(), pick_height(), $urandom(), $urandom());
      end else if (pick < 98) begin
        send_op(OP_SAMPLE, $urandom(),
                full ? $urandom() : $urandom_range(((cur_h - 1) << 8) + 1, 65535),
                $urandom(), $urandom(), $urandom());
      end else begin
        send_op(OP_UNUSED, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin gap_pct = 0; stall_pct = 0; end
      1: begin gap_pct = 45; stall_pct = 0; end
      2: begin gap_pct = 0; stall_pct = 45; end
      default: begin gap_pct = 38; stall_pct = 38; end
    endcase
  endtask

  initial begin
    int phase_w [7] = '{511, 0, 4, 3, 6, 257, 1};
    int phase_h [7] = '{2, 256, 4, 5, 3, 1, 9};
    int phase_fw [7] = '{4, 2, 256, 256, 256, 3, 256};
    int phase_fh [7] = '{2, 4, 256, 256, 256, 2, 256};
    int phase_n [7] = '{45, 45, 50, 45, 45, 40, 40};
    gap_pct = 0;
    stall_pct = 0;
    cur_w = MAX_COLUMNS;
    cur_h = MAX_ROWS;
    fill_w = MAX_COLUMNS;
    fill_h = MAX_ROWS;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data <= '0;
    in_chan.valid <= 1'b0;
    in_chan.operation <= OP_WRITE;
    in_chan.x_coord <= '0;
    in_chan.y_coord <= '0;
    in_chan.height_value <= '0;
    in_chan.target_low <= '0;
    in_chan.target_high <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default 256 x 256 grid: first write seeds the range, then samples over
    // the four written corner cells, a bad sample and the unused code.
    send_op(OP_WRITE, 16'h0180, 16'h01FF, 8388607, 0, 0);
    send_op(OP_WRITE, 16'h0000, 16'h0000, -8388608, 0, 0);
    send_op(OP_WRITE, 16'h0100, 16'h0000, 0, 0, 0);
    send_op(OP_WRITE, 16'h0000, 16'h0100, 12345, 0, 0);
    send_op(OP_SAMPLE, 16'h0080, 16'h0080, 0, 0, 0);
    send_op(OP_SAMPLE, 16'h0000, 16'h0000, 0, 0, 0);
    send_op(OP_SAMPLE, 16'h00FF, 16'h00FF, 0, 0, 0);
    send_op(OP_SAMPLE, 16'hFFFF, 16'h0000, 0, 0, 0);
    send_op(OP_UNUSED, 16'hFFFF, 16'hFFFF, -1, -1, -1);
    drain();

    // Smallest grid: normalize with equal and reversed ranges, last-line
    // samples with a full ratio, and coordinates just outside.
    set_grid(2, 2);
    fill_grid();
    send_op(OP_NORMALIZE, 0, 0, 0, 5, 5);
    send_op(OP_NORMALIZE, 0, 0, 0, -8388608, 8388607);
    send_op(OP_NORMALIZE, 0, 0, 0, 100, -100);
    send_op(OP_WRITE, 16'h0200, 16'h0000, 77, 0, 0);
    send_op(OP_WRITE, 16'h0000, 16'h0200, 77, 0, 0);
    send_op(OP_SAMPLE, 16'h0100, 16'h0100, 0, 0, 0);
    send_op(OP_SAMPLE, 16'h0101, 16'h0000, 0, 0, 0);
    send_op(OP_SAMPLE, 16'h0000, 16'h0101, 0, 0, 0);
    send_op(OP_SAMPLE, 16'h00C0, 16'h0100, 0, 0, 0);
    send_op(OP_NORMALIZE, 0, 0, 0, -8388608, 8388607);
    drain();

    // Fixed phases with extreme and clamped sizes, then random small grids.
    for (int p = 0; p < 7; p++) begin
      set_idling(p);
      set_grid(phase_w[p], phase_h[p]);
      if (phase_fw[p] < cur_w) fill_w = phase_fw[p];
      if (phase_fh[p] < cur_h) fill_h = phase_fh[p];
      fill_grid();
      random_ops(phase_n[p]);
      drain();
    end
    for (int p = 0; p < 2; p++) begin
      set_idling(p + 2);
      set_grid($urandom_range(0, 6), $urandom_range(0, 6));
      fill_grid();
      random_ops(40);
      drain();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
